@@ design/gdi_pkg.sv @@
// Shared widths, constants, tables and control types of the Gregorian date info unit.
package gdi_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int MLEN_W  = 5;
    localparam int ORD_W   = 9;

    // Number of register stages in the datapath, the output register included.
    localparam int NUM_STAGES = 4;

    // Reciprocals for constant division: floor(x * RECIP >> RECIP_SHIFT).
    localparam int RECIP_SHIFT = 17;
    localparam logic [12:0] RECIP_25 = 13'd5243;
    localparam logic [14:0] RECIP_7  = 15'd18725;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;

    localparam logic [WDAY_W-1:0] WDAY_FRI = 3'd5;
    localparam logic [WDAY_W-1:0] WDAY_SAT = 3'd6;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_pipe_ctl;

    typedef struct packed {
        logic [WDAY_W-1:0] weekday;
        logic              end_of_week;
        logic              weekend_flag;
        logic              business_day;
        logic              leap_flag;
        logic [MLEN_W-1:0] month_length;
        logic [ORD_W-1:0]  ordinal_day;
        logic [WDAY_W-1:0] to_week_end;
        logic [MLEN_W-1:0] to_month_end;
        logic [ORD_W-1:0]  to_year_end;
    } t_date_info;

    // Days of the full months before the given one, common year.
    function automatic logic [ORD_W-1:0] days_before(input logic [MONTH_W-1:0] month);
        logic [ORD_W-1:0] d;
        unique case (month)
            4'd0, 4'd1: d = 9'd0;
            4'd2:       d = 9'd31;
            4'd3:       d = 9'd59;
            4'd4:       d = 9'd90;
            4'd5:       d = 9'd120;
            4'd6:       d = 9'd151;
            4'd7:       d = 9'd181;
            4'd8:       d = 9'd212;
            4'd9:       d = 9'd243;
            4'd10:      d = 9'd273;
            4'd11:      d = 9'd304;
            4'd12:      d = 9'd334;
            default:    d = 9'd365;
        endcase
        return d;
    endfunction

    // Days in the month, common year; codes that name no month give zero.
    function automatic logic [MLEN_W-1:0] month_days(input logic [MONTH_W-1:0] month);
        logic [MLEN_W-1:0] d;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // floor(31 * m / 12) where m is the month shifted to start in March.
    function automatic logic [5:0] month_offset(input logic [MONTH_W-1:0] month);
        logic [5:0] d;
        unique case (month)
            4'd0:  d = 6'd25;
            4'd1:  d = 6'd28;
            4'd2:  d = 6'd31;
            4'd3:  d = 6'd2;
            4'd4:  d = 6'd5;
            4'd5:  d = 6'd7;
            4'd6:  d = 6'd10;
            4'd7:  d = 6'd12;
            4'd8:  d = 6'd15;
            4'd9:  d = 6'd18;
            4'd10: d = 6'd20;
            4'd11: d = 6'd23;
            4'd12: d = 6'd25;
            4'd13: d = 6'd28;
            4'd14: d = 6'd31;
            default: d = 6'd33;
        endcase
        return d;
    endfunction

endpackage

@@ design/gdi_if.sv @@
// Request channel interfaces of the Gregorian date info unit.
interface gdi_date_if;
    logic                           valid;
    logic                           ready;
    logic [gdi_pkg::YEAR_W-1:0]     year_value;
    logic [gdi_pkg::MONTH_W-1:0]    month_value;
    logic [gdi_pkg::DAY_W-1:0]      day_value;

    modport source (output valid, year_value, month_value, day_value, input ready);
    modport sink   (input valid, year_value, month_value, day_value, output ready);
endinterface

interface gdi_info_if;
    logic                           valid;
    logic                           ready;
    logic [gdi_pkg::WDAY_W-1:0]     weekday;
    logic                           end_of_week;
    logic                           weekend_flag;
    logic                           business_day;
    logic                           leap_flag;
    logic [gdi_pkg::MLEN_W-1:0]     month_length;
    logic [gdi_pkg::ORD_W-1:0]      ordinal_day;
    logic [gdi_pkg::WDAY_W-1:0]     to_week_end;
    logic [gdi_pkg::MLEN_W-1:0]     to_month_end;
    logic [gdi_pkg::ORD_W-1:0]      to_year_end;

    modport source (output valid, weekday, end_of_week, weekend_flag, business_day,
                    leap_flag, month_length, ordinal_day, to_week_end, to_month_end,
                    to_year_end, input ready);
    modport sink   (input valid, weekday, end_of_week, weekend_flag, business_day,
                    leap_flag, month_length, ordinal_day, to_week_end, to_month_end,
                    to_year_end, output ready);
endinterface

@@ design/gdi_core.sv @@
// Four-stage datapath of the Gregorian date info unit.
module gdi_core (
    input  logic                          i_clk,
    input  gdi_pkg::t_pipe_ctl            i_ctl,
    input  logic [gdi_pkg::YEAR_W-1:0]    i_year,
    input  logic [gdi_pkg::MONTH_W-1:0]   i_month,
    input  logic [gdi_pkg::DAY_W-1:0]     i_day,
    output gdi_pkg::t_date_info           o_info
);
    import gdi_pkg::*;

    // Stage 1: shifted year and the two reciprocal products for division by 100.
    logic [YEAR_W-1:0]  r1_year;
    logic [14:0]        r1_y;
    logic [MONTH_W-1:0] r1_month;
    logic [DAY_W-1:0]   r1_day;
    logic [24:0]        r1_prod_year;
    logic [25:0]        r1_prod_y;
    logic               n1_jan_feb;
    logic [14:0]        n1_y;

    assign n1_jan_feb = (i_month <= MONTH_FEB);
    assign n1_y = 15'(i_year) + 15'd400 - 15'(n1_jan_feb);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r1_year      <= i_year;
            r1_y         <= n1_y;
            r1_month     <= i_month;
            r1_day       <= i_day;
            r1_prod_year <= 25'(i_year[YEAR_W-1:2]) * 25'(RECIP_25);
            r1_prod_y    <= 26'(n1_y[14:2]) * 26'(RECIP_25);
        end
    end

    // Stage 2: leap year and the weekday sum before reduction modulo 7.
    logic [7:0]         n2_q_year;
    logic [8:0]         n2_q_y;
    logic               n2_cent;
    logic               n2_leap;
    logic [15:0]        n2_sum;
    logic [15:0]        r2_sum;
    logic               r2_leap;
    logic [MONTH_W-1:0] r2_month;
    logic [DAY_W-1:0]   r2_day;

    assign n2_q_year = r1_prod_year[24:RECIP_SHIFT];
    assign n2_q_y    = r1_prod_y[25:RECIP_SHIFT];
    assign n2_cent   = (r1_year == 14'(14'(n2_q_year) * 14'd100));
    assign n2_leap   = ((r1_year[1:0] == 2'd0) && !n2_cent)
                     || (n2_cent && (n2_q_year[1:0] == 2'd0));
    assign n2_sum    = 16'(r1_day) + 16'(r1_y) + 16'(r1_y[14:2]) - 16'(n2_q_y)
                     + 16'(n2_q_y[8:2]) + 16'(month_offset(r1_month));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r2_sum   <= n2_sum;
            r2_leap  <= n2_leap;
            r2_month <= r1_month;
            r2_day   <= r1_day;
        end
    end

    // Stage 3: reciprocal product for modulo 7, month length and ordinal day.
    logic [MLEN_W-1:0]  n3_mlen;
    logic [ORD_W-1:0]   n3_ord;
    logic [30:0]        r3_prod;
    logic [15:0]        r3_sum;
    logic               r3_leap;
    logic [MLEN_W-1:0]  r3_mlen;
    logic [ORD_W-1:0]   r3_ord;
    logic [MLEN_W-1:0]  r3_to_month;

    always_comb begin
        n3_mlen = month_days(r2_month);
        if (r2_month == MONTH_FEB && r2_leap) begin
            n3_mlen = 5'd29;
        end
        n3_ord = days_before(r2_month) + ORD_W'(r2_day)
               + ORD_W'((r2_month >= MONTH_MAR) && r2_leap);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r3_prod     <= 31'(r2_sum) * 31'(RECIP_7);
            r3_sum      <= r2_sum;
            r3_leap     <= r2_leap;
            r3_mlen     <= n3_mlen;
            r3_ord      <= n3_ord;
            r3_to_month <= (n3_mlen > r2_day) ? (n3_mlen - r2_day) : '0;
        end
    end

    // Stage 4: weekday and the output register.
    logic [13:0]        n4_q7;
    logic [WDAY_W-1:0]  n4_wday;
    logic [ORD_W-1:0]   n4_ylen;
    t_date_info         r4_info;

    assign n4_q7   = r3_prod[30:RECIP_SHIFT];
    assign n4_wday = WDAY_W'(r3_sum - 16'(16'(n4_q7) * 16'd7));
    assign n4_ylen = r3_leap ? 9'd366 : 9'd365;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r4_info.weekday      <= n4_wday;
            r4_info.end_of_week  <= (n4_wday == WDAY_SAT);
            r4_info.weekend_flag <= (n4_wday == WDAY_FRI) || (n4_wday == WDAY_SAT);
            r4_info.business_day <= !((n4_wday == WDAY_FRI) || (n4_wday == WDAY_SAT));
            r4_info.leap_flag    <= r3_leap;
            r4_info.month_length <= r3_mlen;
            r4_info.ordinal_day  <= r3_ord;
            r4_info.to_week_end  <= WDAY_SAT - n4_wday;
            r4_info.to_month_end <= r3_to_month;
            r4_info.to_year_end  <= (n4_ylen > r3_ord) ? (n4_ylen - r3_ord) : '0;
        end
    end

    assign o_info = r4_info;

endmodule

@@ design/gregorian_date_info_unit.sv @@
// Top level of the Gregorian date info unit: handshake control around the datapath.
//
//  Channel   Dir  Modport  Request carries
//  i_date    in   sink     year_value, month_value, day_value
//  o_info    out  source   weekday, week/weekend/business flags, leap flag,
//                          month length, ordinal day, days left in week/month/year
//
// Every request passes four register stages, and one request is taken every cycle
// while the output flows. The stages are the two divide-by-100 products, the
// weekday sum with the leap decision, the modulo-7 product with the month tables,
// and the output register. Each stage holds a valid bit; a stage loads whenever it
// is empty or its contents move on, so bubbles close up while the output is
// stalled and a stalled result is held unchanged. The synchronous active-low reset
// clears only the valid bits; the datapath registers are not reset.
module gregorian_date_info_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gdi_date_if.sink       i_date,
    gdi_info_if.source     o_info
);
    import gdi_pkg::*;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    t_pipe_ctl             pipe_ctl;
    t_date_info            info;

    // A stage may load when it is empty or when the stage after it loads.
    // The last stage moves on when the consumer takes the result.
    always_comb begin
        pipe_ctl.load[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || o_info.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            pipe_ctl.load[k] = !r_valid[k] || pipe_ctl.load[k+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (pipe_ctl.load[0]) begin
            n_valid[0] = i_date.valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (pipe_ctl.load[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    gdi_core u_core (
        .i_clk   (i_clk),
        .i_ctl   (pipe_ctl),
        .i_year  (i_date.year_value),
        .i_month (i_date.month_value),
        .i_day   (i_date.day_value),
        .o_info  (info)
    );

    // The first stage takes a request whenever it can load.
    assign i_date.ready = pipe_ctl.load[0];

    assign o_info.valid        = r_valid[NUM_STAGES-1];
    assign o_info.weekday      = info.weekday;
    assign o_info.end_of_week  = info.end_of_week;
    assign o_info.weekend_flag = info.weekend_flag;
    assign o_info.business_day = info.business_day;
    assign o_info.leap_flag    = info.leap_flag;
    assign o_info.month_length = info.month_length;
    assign o_info.ordinal_day  = info.ordinal_day;
    assign o_info.to_week_end  = info.to_week_end;
    assign o_info.to_month_end = info.to_month_end;
    assign o_info.to_year_end  = info.to_year_end;

endmodule
